### rtl/interrupt_vector_allocator_assert.svh
// Assertion macros for the interrupt vector allocator checker.
// Needs nothing else; included by iva_checker, the file that asserts.
`ifndef INTERRUPT_VECTOR_ALLOCATOR_ASSERT_SVH
`define INTERRUPT_VECTOR_ALLOCATOR_ASSERT_SVH

// Property checked at every rising clock edge outside reset.
`define IVA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define IVA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `IVA_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

### rtl/iva_pkg.sv
// Shared types, constants and mark-table functions of the interrupt vector allocator.
// Depends on nothing; used by every module of the block.
`default_nettype none

package iva_pkg;

    localparam int VEC_W         = 8;
    localparam int ROW_BITS      = 32;
    localparam int BIT_IDX_W     = 5;
    localparam int NUM_VECTORS_D = 256;
    localparam int FIRST_DYN_D   = 48;

    localparam int SYSCALL_VECTOR  = 'h80;
    localparam int TIMER_VECTOR    = 64;
    localparam int SPURIOUS_VECTOR = 'hFF;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic                 found;
        logic [BIT_IDX_W-1:0] bit_idx;
    } t_scan_res;

    // Marks set after reset for one row of the table.
    function automatic logic [ROW_BITS-1:0] reset_row(input int row, input int num,
                                                      input int first);
        logic [ROW_BITS-1:0] bits;
        int                  v;
        bits = '0;
        for (int b = 0; b < ROW_BITS; b++) begin
            v = row * ROW_BITS + b;
            if (v < num && (v < first || v == TIMER_VECTOR || v == SYSCALL_VECTOR
                            || v == SPURIOUS_VECTOR)) begin
                bits[b] = 1'b1;
            end
        end
        return bits;
    endfunction

    // Positions of one row that an allocation may hand out.
    function automatic logic [ROW_BITS-1:0] alloc_mask(input int row, input int num,
                                                       input int first);
        logic [ROW_BITS-1:0] bits;
        int                  v;
        bits = '0;
        for (int b = 0; b < ROW_BITS; b++) begin
            v = row * ROW_BITS + b;
            bits[b] = (v >= first) && (v < num) && (v != SYSCALL_VECTOR);
        end
        return bits;
    endfunction

endpackage

`default_nettype wire

### rtl/iva_row_scan.sv
// Lowest-free-position finder over one 32-bit row of the used-mark table.
// Depends on iva_pkg for the row mask function and the result struct.
`default_nettype none

module iva_row_scan #(
    parameter int NUM_VECTORS   = iva_pkg::NUM_VECTORS_D,
    parameter int FIRST_DYNAMIC = iva_pkg::FIRST_DYN_D,
    parameter int ROW_W         = 3
) (
    input  wire logic [ROW_W-1:0]             i_row,
    input  wire logic [iva_pkg::ROW_BITS-1:0] i_marks,
    output iva_pkg::t_scan_res                o_res
);

    logic [iva_pkg::ROW_BITS-1:0] free_bits;

    assign free_bits = ~i_marks & iva_pkg::alloc_mask(int'(i_row), NUM_VECTORS, FIRST_DYNAMIC);

    // Walk from the top so the lowest free position wins.
    always_comb begin
        o_res = '0;
        for (int b = iva_pkg::ROW_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                o_res.found   = 1'b1;
                o_res.bit_idx = iva_pkg::BIT_IDX_W'(b);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/interrupt_vector_allocator.sv
// Interrupt vector allocator; depends on iva_pkg and iva_row_scan.
// A free command is applied at its transfer edge.
// An allocate scans one 32-vector row per cycle from the row of the first dynamic vector; the
// scan stops at the first row with a free position or at the last row, and its grant is loaded
// into the output register once that register is free; no new command is taken until then.
// Synchronous active-low reset loads the reserved marks and empties the output.
`default_nettype none

module interrupt_vector_allocator #(
    parameter int NUM_VECTORS   = iva_pkg::NUM_VECTORS_D,
    parameter int FIRST_DYNAMIC = iva_pkg::FIRST_DYN_D
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic                      i_command,
    input  wire logic [iva_pkg::VEC_W-1:0] i_vector_to_free,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic [iva_pkg::VEC_W-1:0]      o_granted_vector
);

    localparam int ROWS      = (NUM_VECTORS + iva_pkg::ROW_BITS - 1) / iva_pkg::ROW_BITS;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int START_ROW = FIRST_DYNAMIC / iva_pkg::ROW_BITS;
    localparam int LAST_ROW  = ROWS - 1;

    iva_pkg::t_state              r_state, n_state;
    logic [ROW_W-1:0]             r_row, n_row;
    logic [iva_pkg::ROW_BITS-1:0] r_marks [ROWS];
    logic                         r_out_valid, n_out_valid;
    logic [iva_pkg::VEC_W-1:0]    r_vec, n_vec;

    logic                         in_fire;
    logic                         out_free;
    logic                         free_ok;
    logic                         scan_done;
    logic                         load_out;
    logic                         wr_en;
    logic [ROW_W-1:0]             free_row;
    logic [ROW_W-1:0]             rd_row;
    logic [iva_pkg::ROW_BITS-1:0] rd_data;
    logic [iva_pkg::ROW_BITS-1:0] wr_data;
    iva_pkg::t_scan_res           scan_res;

    assign in_fire   = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign free_row  = ROW_W'(i_vector_to_free >> iva_pkg::BIT_IDX_W);
    assign free_ok   = (int'(i_vector_to_free) >= FIRST_DYNAMIC)
                    && (int'(i_vector_to_free) != iva_pkg::SYSCALL_VECTOR)
                    && (int'(i_vector_to_free) < NUM_VECTORS);
    // One read port: the free target while idle, the scan row otherwise.
    assign rd_row    = (r_state == iva_pkg::S_IDLE) ? free_row : r_row;
    assign rd_data   = r_marks[rd_row];
    assign scan_done = scan_res.found || (r_row == ROW_W'(LAST_ROW));

    iva_row_scan #(
        .NUM_VECTORS  (NUM_VECTORS),
        .FIRST_DYNAMIC(FIRST_DYNAMIC),
        .ROW_W        (ROW_W)
    ) u_scan (
        .i_row  (r_row),
        .i_marks(rd_data),
        .o_res  (scan_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iva_pkg::S_IDLE: begin
                if (in_fire && i_command == iva_pkg::CMD_ALLOC) begin
                    n_state = iva_pkg::S_SCAN;
                end
            end
            iva_pkg::S_SCAN: begin
                if (scan_done && out_free) begin
                    n_state = iva_pkg::S_IDLE;
                end
            end
            default: n_state = iva_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        wr_en      = 1'b0;
        wr_data    = rd_data;
        load_out   = 1'b0;
        n_row      = r_row;
        unique case (r_state)
            iva_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                n_row      = ROW_W'(START_ROW);
                if (in_fire && i_command == iva_pkg::CMD_FREE && free_ok) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data & ~(iva_pkg::ROW_BITS'(1)
                                          << i_vector_to_free[iva_pkg::BIT_IDX_W-1:0]);
                end
            end
            iva_pkg::S_SCAN: begin
                if (scan_done) begin
                    // Hold the scan until the output register can take the grant.
                    if (out_free) begin
                        load_out = 1'b1;
                        wr_en    = scan_res.found;
                        wr_data  = rd_data | (iva_pkg::ROW_BITS'(1) << scan_res.bit_idx);
                    end
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_vec       = r_vec;
        if (load_out) begin
            n_out_valid = 1'b1;
            n_vec       = scan_res.found ? iva_pkg::VEC_W'({r_row, scan_res.bit_idx})
                                         : '0;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iva_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_row       <= ROW_W'(START_ROW);
            for (int r = 0; r < ROWS; r++) begin
                r_marks[r] <= iva_pkg::reset_row(r, NUM_VECTORS, FIRST_DYNAMIC);
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_row       <= n_row;
            if (wr_en) begin
                r_marks[rd_row] <= wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    assign o_out_valid      = r_out_valid;
    assign o_granted_vector = r_vec;

endmodule

`default_nettype wire

### rtl/iva_checker.sv
// Port-level checks of the interrupt vector allocator, bound to its top level.
// Depends on iva_pkg and the assertion macros header.
`default_nettype none
`include "interrupt_vector_allocator_assert.svh"

module iva_checker #(
    parameter int NUM_VECTORS   = iva_pkg::NUM_VECTORS_D,
    parameter int FIRST_DYNAMIC = iva_pkg::FIRST_DYN_D
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      o_in_ready,
    input wire logic                      i_command,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_ready,
    input wire logic [iva_pkg::VEC_W-1:0] o_granted_vector
);

    // The syscall vector is never handed out.
    `IVA_ASSERT_NEVER(a_no_syscall, i_clk, i_rst_n, o_out_valid && int'(o_granted_vector) == iva_pkg::SYSCALL_VECTOR, "syscall vector granted")

    // A grant is zero or lies in the dynamic range.
    `IVA_ASSERT(a_grant_range, i_clk, i_rst_n, o_out_valid && o_granted_vector != '0 |-> int'(o_granted_vector) >= FIRST_DYNAMIC && int'(o_granted_vector) < NUM_VECTORS, "grant outside dynamic range")

    // An accepted allocate blocks the input while its scan runs.
    `IVA_ASSERT(a_alloc_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_command == iva_pkg::CMD_ALLOC |=> !o_in_ready, "input ready during allocation scan")

    // A stalled grant holds its value.
    `IVA_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_granted_vector), "stalled grant changed")

endmodule

bind interrupt_vector_allocator iva_checker #(
    .NUM_VECTORS  (NUM_VECTORS),
    .FIRST_DYNAMIC(FIRST_DYNAMIC)
) u_iva_checker (.*);

`default_nettype wire

### test/iva_alloc_checker.sv
`timescale 1ns / 1ps
// Checker for interrupt_vector_allocator: follows both transfers and keeps its own used-mark table.
// It compares every granted vector with the predicted one. Depends on iva_pkg.
module iva_alloc_checker
    import iva_pkg::*;
#(
    parameter int NUM_VECTORS   = NUM_VECTORS_D,
    parameter int FIRST_DYNAMIC = FIRST_DYN_D
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_ready,
    input  wire logic             i_command,
    input  wire logic [VEC_W-1:0] i_vector_to_free,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_ready,
    input  wire logic [VEC_W-1:0] i_granted_vector,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_alloc_count,
    output int                    o_exhausted_count,
    output int                    o_free_count,
    output int                    o_protected_count
);

    logic [NUM_VECTORS-1:0] used_marks;
    logic [VEC_W-1:0]       grants_due[$];
    int                     fail_tally      = 0;
    int                     alloc_tally     = 0;
    int                     exhausted_tally = 0;
    int                     free_tally      = 0;
    int                     protected_tally = 0;

    // First fit from the first dynamic vector up; the syscall vector is never handed out.
    function automatic logic [VEC_W-1:0] claim_lowest_free();
        for (int v = FIRST_DYNAMIC; v < NUM_VECTORS; v++) begin
            if (v != SYSCALL_VECTOR && !used_marks[v]) begin
                used_marks[v] = 1'b1;
                return VEC_W'(v);
            end
        end
        return '0;
    endfunction

    always @(posedge i_clk) begin : watch
        logic [VEC_W-1:0] want;
        logic [VEC_W-1:0] grant;
        if (!i_rst_n) begin
            for (int v = 0; v < NUM_VECTORS; v++) begin
                used_marks[v] = (v < FIRST_DYNAMIC) || (v == TIMER_VECTOR)
                                || (v == SYSCALL_VECTOR) || (v == SPURIOUS_VECTOR);
            end
            grants_due.delete();
        end else begin
            // A grant leaving now always belongs to an allocation accepted earlier.
            if (i_out_valid && i_out_ready) begin
                if (grants_due.size() == 0) begin
                    $display("%0t: granted vector %0d with no allocation outstanding",
                             $time, i_granted_vector);
                    fail_tally++;
                end else begin
                    want = grants_due.pop_front();
                    if (want !== i_granted_vector) begin
                        $display("%0t: granted vector mismatch, expected %0d, actual %0d",
                                 $time, want, i_granted_vector);
                        fail_tally++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_command == CMD_ALLOC) begin
                    grant = claim_lowest_free();
                    grants_due.push_back(grant);
                    alloc_tally++;
                    if (grant == '0) begin
                        exhausted_tally++;
                    end
                end else begin
                    free_tally++;
                    if (i_vector_to_free < FIRST_DYNAMIC || i_vector_to_free == SYSCALL_VECTOR)
                    begin
                        protected_tally++;
                    end else if (i_vector_to_free < NUM_VECTORS) begin
                        used_marks[i_vector_to_free] = 1'b0;
                    end
                end
            end
        end
        o_fail_count      <= fail_tally;
        o_pending         <= grants_due.size();
        o_alloc_count     <= alloc_tally;
        o_exhausted_count <= exhausted_tally;
        o_free_count      <= free_tally;
        o_protected_count <= protected_tally;
    end

endmodule

### test/tb_interrupt_vector_allocator.sv
`timescale 1ns / 1ps
// Testbench top for interrupt_vector_allocator: clock, reset, command stimulus and verdict.
// Depends on iva_pkg, the allocator RTL and iva_alloc_checker.
module tb_interrupt_vector_allocator;
    import iva_pkg::*;

    logic             clk            = 1'b0;
    logic             rst_n          = 1'b0;
    logic             in_valid       = 1'b0;
    logic             in_ready;
    logic             command        = CMD_ALLOC;
    logic [VEC_W-1:0] vector_to_free = '0;
    logic             out_valid;
    logic             out_ready      = 1'b0;
    logic [VEC_W-1:0] granted_vector;
    bit               send_quiet     = 1'b0;
    bit               sink_quiet     = 1'b0;
    int               fail_count;
    int               pending;
    int               alloc_count;
    int               exhausted_count;
    int               free_count;
    int               protected_count;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    interrupt_vector_allocator DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_command        (command),
        .i_vector_to_free (vector_to_free),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_granted_vector (granted_vector)
    );

    iva_alloc_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_command         (command),
        .i_vector_to_free  (vector_to_free),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_granted_vector  (granted_vector),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_alloc_count     (alloc_count),
        .o_exhausted_count (exhausted_count),
        .o_free_count      (free_count),
        .o_protected_count (protected_count)
    );

    // Waits a random gap, then holds the command until its transfer.
    task automatic issue_command(input logic cmd, input logic [VEC_W-1:0] vec);
        int gap;
        if ($urandom_range(0, 31) == 0) begin
            send_quiet = !send_quiet;
        end
        gap = send_quiet ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid       <= 1'b1;
        command        <= cmd;
        vector_to_free <= vec;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    initial begin : result_sink
        int stall;
        @(posedge rst_n);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                sink_quiet = !sink_quiet;
            end
            stall = sink_quiet ? 0 : $urandom_range(0, 7);
            repeat (stall) begin
                @(negedge clk);
                out_ready <= 1'b0;
            end
            @(negedge clk);
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial begin : stimulus
        int               alloc_pct;
        logic [VEC_W-1:0] target;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: protected vectors, reserved but freeable ones, double frees.
        issue_command(CMD_ALLOC, 8'h00);
        issue_command(CMD_FREE, 8'h00);
        issue_command(CMD_FREE, 8'd47);
        issue_command(CMD_FREE, 8'(SYSCALL_VECTOR));
        issue_command(CMD_ALLOC, 8'hFF);
        issue_command(CMD_FREE, 8'd48);
        issue_command(CMD_FREE, 8'd48);
        issue_command(CMD_ALLOC, 8'h55);
        issue_command(CMD_FREE, 8'(TIMER_VECTOR));
        issue_command(CMD_FREE, 8'(SPURIOUS_VECTOR));
        issue_command(CMD_FREE, 8'(SPURIOUS_VECTOR));
        issue_command(CMD_FREE, 8'd200);
        issue_command(CMD_ALLOC, 8'hAA);
        issue_command(CMD_FREE, 8'd127);
        issue_command(CMD_FREE, 8'd129);
        issue_command(CMD_FREE, 8'h55);
        issue_command(CMD_FREE, 8'hAA);
        issue_command(CMD_FREE, 8'd1);
        issue_command(CMD_ALLOC, 8'h00);
        issue_command(CMD_ALLOC, 8'hFF);

        // Random part: fill the table past exhaustion, drain it, then mix.
        for (int n = 0; n < 750; n++) begin
            alloc_pct = (n < 260) ? 90 : (n < 510) ? 20 : 50;
            if ($urandom_range(1, 100) <= alloc_pct) begin
                issue_command(CMD_ALLOC, 8'($urandom()));
            end else begin
                if ($urandom_range(0, 4) == 0) begin
                    target = 8'($urandom());
                end else begin
                    target = 8'($urandom_range(FIRST_DYN_D, 255));
                end
                issue_command(CMD_FREE, target);
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (16) @(negedge clk);
        $display("Covered %0d allocations, %0d of them with no vector free, and %0d frees,",
                 alloc_count, exhausted_count, free_count);
        $display("%0d of the frees aimed at protected vectors.", protected_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Timeout waiting for the allocator to finish.");
        $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/iva_pkg.sv
rtl/iva_row_scan.sv
rtl/interrupt_vector_allocator.sv
rtl/iva_checker.sv
test/iva_alloc_checker.sv
test/tb_interrupt_vector_allocator.sv
